/* src/tssg_pkg.sv */
// Package for the triangle scanline span generator.
// Holds the shared widths, default parameter values and the command and status
// structs between the controller and the datapath. Depends on nothing.
package tssg_pkg;

    localparam int ROW_W = 6;
    localparam int DEF_ROWS = 64;
    localparam int DEF_X_WIDTH = 10;

    typedef struct packed {
        logic load;       // register the sorted vertices of an accepted item
        logic div_start;  // start the long, upper and lower edge dividers
        logic init;       // load the edge accumulators and the first row
        logic emit;       // write the current span to the output register
    } cmd_t;

    typedef struct packed {
        logic flat;       // top and bottom share a row: no spans
        logic div_busy;   // edge dividers still running
        logic out_free;   // output register can take a span this cycle
        logic last_row;   // current row is the final span of the triangle
    } status_t;

endpackage

/* src/triangle_scanline_span_generator.sv */
// Top level of the triangle scanline span generator.
// Joins tssg_ctrl and tssg_datapath; parameters default from tssg_pkg.
//
// Usage:
//   The tri channel (tri_valid, tri_stall) takes one item: a triangle with
//   three vertices ax/ay, bx/by, cx/cy. The span channel (span_valid,
//   span_stall) returns one span per row from the top vertex row up to, but
//   not including, the bottom vertex row, in increasing row order; last marks
//   the final span. A triangle whose three rows are equal gives no span.
//   After an item is accepted, the controller launches the edge dividers,
//   waits for the serial edge dividers, sets up the edges and then fills the
//   output register with the first span. Spans then follow one per cycle
//   while span_stall is low; the bit-serial edge division makes up most of
//   the time before the first span. A triangle with no span returns to idle
//   without starting the edge dividers.
//   tri_stall stays high from acceptance until the last span has entered the
//   output register; the next item is taken while that span still waits.
//   When span_stall is high, the span in the output register holds and span
//   generation pauses. Reset clears the controller and the output valid;
//   no item is in flight afterward.
module triangle_scanline_span_generator #(
    parameter int ROWS    = tssg_pkg::DEF_ROWS,
    parameter int X_WIDTH = tssg_pkg::DEF_X_WIDTH
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       tri_valid,
    output logic                       tri_stall,
    input  logic signed [X_WIDTH-1:0]  ax,
    input  logic [tssg_pkg::ROW_W-1:0] ay,
    input  logic signed [X_WIDTH-1:0]  bx,
    input  logic [tssg_pkg::ROW_W-1:0] by,
    input  logic signed [X_WIDTH-1:0]  cx,
    input  logic [tssg_pkg::ROW_W-1:0] cy,
    output logic                       span_valid,
    input  logic                       span_stall,
    output logic [tssg_pkg::ROW_W-1:0] row,
    output logic signed [X_WIDTH-1:0]  x_long,
    output logic signed [X_WIDTH-1:0]  x_short,
    output logic                       last
);

    tssg_pkg::cmd_t    cmd;
    tssg_pkg::status_t status;

    tssg_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .tri_valid (tri_valid),
        .tri_stall (tri_stall),
        .status    (status),
        .cmd       (cmd)
    );

    tssg_datapath #(
        .ROWS    (ROWS),
        .X_WIDTH (X_WIDTH)
    ) u_datapath (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .status     (status),
        .ax         (ax),
        .ay         (ay),
        .bx         (bx),
        .by         (by),
        .cx         (cx),
        .cy         (cy),
        .span_stall (span_stall),
        .span_valid (span_valid),
        .row        (row),
        .x_long     (x_long),
        .x_short    (x_short),
        .last       (last)
    );

endmodule

/* src/tssg_div.sv */
// Serial divider for one triangle edge: floor quotient and remainder of dx / dy.
// Restoring division, one quotient bit per cycle. Uses tssg_pkg for the row width.
module tssg_div #(
    parameter int X_WIDTH = tssg_pkg::DEF_X_WIDTH
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      start,
    input  logic signed [X_WIDTH:0]   dividend,
    input  logic [tssg_pkg::ROW_W-1:0] divisor,
    output logic                      busy,
    output logic [X_WIDTH-1:0]        quot,
    output logic [tssg_pkg::ROW_W-1:0] rem
);

    localparam int DW = X_WIDTH + 1;
    localparam int CW = $clog2(DW + 1);
    localparam int RW = tssg_pkg::ROW_W;

    logic          busy_reg, busy_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic [DW-1:0] quo_reg, quo_next;
    logic [RW-1:0] rem_reg, rem_next;
    logic [RW-1:0] dvs_reg, dvs_next;
    logic          neg_reg, neg_next;

    logic [RW:0]   shifted;
    logic [RW:0]   trial;
    logic [DW-1:0] mag;
    logic [DW-1:0] quo_fix;

    assign mag     = dividend[DW-1] ? DW'(-dividend) : DW'(dividend);
    assign shifted = {rem_reg, quo_reg[DW-1]};
    assign trial   = shifted - {1'b0, dvs_reg};

    always_comb
    begin
        busy_next = busy_reg;
        cnt_next  = cnt_reg;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        neg_next  = neg_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = CW'(DW);
            quo_next  = mag;
            rem_next  = '0;
            dvs_next  = divisor;
            neg_next  = dividend[DW-1];
        end
        else if (busy_reg)
        begin
            if (shifted >= {1'b0, dvs_reg})
            begin
                rem_next = trial[RW-1:0];
                quo_next = {quo_reg[DW-2:0], 1'b1};
            end
            else
            begin
                rem_next = shifted[RW-1:0];
                quo_next = {quo_reg[DW-2:0], 1'b0};
            end
            cnt_next = cnt_reg - CW'(1);
            if (cnt_reg == CW'(1))
            begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
        neg_reg <= neg_next;
    end

    // A negative dividend with a remainder rounds the quotient down by one more
    // and turns the remainder around so that it stays non-negative.
    always_comb
    begin
        if (neg_reg && (rem_reg != '0))
        begin
            quo_fix = ~quo_reg;
            rem     = dvs_reg - rem_reg;
        end
        else if (neg_reg)
        begin
            quo_fix = DW'(-quo_reg);
            rem     = rem_reg;
        end
        else
        begin
            quo_fix = quo_reg;
            rem     = rem_reg;
        end
    end

    assign quot = quo_fix[X_WIDTH-1:0];
    assign busy = busy_reg;

endmodule

/* src/tssg_datapath.sv */
// Datapath of the span generator: vertex sort, long, upper and lower edge dividers,
// their edge accumulators and the output register. Uses tssg_pkg and tssg_div.
module tssg_datapath #(
    parameter int ROWS    = tssg_pkg::DEF_ROWS,
    parameter int X_WIDTH = tssg_pkg::DEF_X_WIDTH
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  tssg_pkg::cmd_t                      cmd,
    output tssg_pkg::status_t                   status,
    input  logic signed [X_WIDTH-1:0]           ax,
    input  logic [tssg_pkg::ROW_W-1:0]          ay,
    input  logic signed [X_WIDTH-1:0]           bx,
    input  logic [tssg_pkg::ROW_W-1:0]          by,
    input  logic signed [X_WIDTH-1:0]           cx,
    input  logic [tssg_pkg::ROW_W-1:0]          cy,
    input  logic                                span_stall,
    output logic                                span_valid,
    output logic [tssg_pkg::ROW_W-1:0]          row,
    output logic signed [X_WIDTH-1:0]           x_long,
    output logic signed [X_WIDTH-1:0]           x_short,
    output logic                                last
);

    localparam int RW = tssg_pkg::ROW_W;
    localparam int XW = X_WIDTH;
    localparam int RowMax = ROWS - 1;

    // Sorted vertices: top, middle, bottom.
    logic [XW-1:0] tx_reg, mx_reg, bx_reg;
    logic [RW-1:0] ty_reg, my_reg, by_reg;

    // Edge accumulators: long edge, upper short edge, lower short edge.
    logic [XW-1:0] ql_reg, qu_reg, qw_reg;
    logic [RW-1:0] rl_reg, ru_reg, rw_reg;
    logic [RW-1:0] cur_row_reg;

    logic          out_valid_reg;
    logic [RW-1:0] out_row_reg;
    logic [XW-1:0] out_xl_reg, out_xs_reg;
    logic          out_last_reg;

    logic [RW-1:0] ya, yb, yc;
    logic [XW-1:0] s0x, s1x, s2x, t0x, t1x, t2x;
    logic [RW-1:0] s0y, s1y, s2y, t0y, t1y, t2y;

    logic [XW-1:0] qd_l, qd_u, qd_w;
    logic [RW-1:0] rd_l, rd_u, rd_w;
    logic [2:0]    busy;

    logic          lower;
    logic [XW-1:0] step_ql, step_qu, step_qw;
    logic [RW-1:0] step_rl, step_ru, step_rw;

    function automatic logic [XW+RW-1:0] edge_step(
        input logic [XW-1:0] q,
        input logic [RW-1:0] r,
        input logic [XW-1:0] qd,
        input logic [RW-1:0] rd,
        input logic [RW-1:0] dy
    );
        logic [RW:0] sum;
        logic [RW:0] diff;
        begin
            sum  = {1'b0, r} + {1'b0, rd};
            diff = sum - {1'b0, dy};
            if (sum >= {1'b0, dy})
            begin
                edge_step = {q + qd + XW'(1), diff[RW-1:0]};
            end
            else
            begin
                edge_step = {q + qd, sum[RW-1:0]};
            end
        end
    endfunction

    // Floor quotient to quotient truncated toward zero.
    function automatic logic [XW-1:0] trunc_x(
        input logic [XW-1:0] q,
        input logic [RW-1:0] r
    );
        begin
            trunc_x = (q[XW-1] && (r != '0)) ? q + XW'(1) : q;
        end
    endfunction

    assign ya = (int'(ay) > RowMax) ? RW'(RowMax) : ay;
    assign yb = (int'(by) > RowMax) ? RW'(RowMax) : by;
    assign yc = (int'(cy) > RowMax) ? RW'(RowMax) : cy;

    // Selection sort on three entries; on equal rows the later entry wins.
    always_comb
    begin
        // First pass: find the minimum, later position wins ties.
        if (yc <= ((yb <= ya) ? yb : ya))
        begin
            s0x = cx; s0y = yc; s1x = bx; s1y = yb; s2x = ax; s2y = ya;
        end
        else if (yb <= ya)
        begin
            s0x = bx; s0y = yb; s1x = ax; s1y = ya; s2x = cx; s2y = yc;
        end
        else
        begin
            s0x = ax; s0y = ya; s1x = bx; s1y = yb; s2x = cx; s2y = yc;
        end
        t0x = s0x; t0y = s0y;
        if (s2y <= s1y)
        begin
            t1x = s2x; t1y = s2y; t2x = s1x; t2y = s1y;
        end
        else
        begin
            t1x = s1x; t1y = s1y; t2x = s2x; t2y = s2y;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            tx_reg <= t0x; ty_reg <= t0y;
            mx_reg <= t1x; my_reg <= t1y;
            bx_reg <= t2x; by_reg <= t2y;
        end
    end

    tssg_div #(.X_WIDTH(XW)) u_div_long (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.div_start),
        .dividend ((XW+1)'($signed(bx_reg)) - (XW+1)'($signed(tx_reg))),
        .divisor  (by_reg - ty_reg),
        .busy     (busy[0]),
        .quot     (qd_l),
        .rem      (rd_l)
    );

    tssg_div #(.X_WIDTH(XW)) u_div_upper (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.div_start),
        .dividend ((XW+1)'($signed(mx_reg)) - (XW+1)'($signed(tx_reg))),
        .divisor  (my_reg - ty_reg),
        .busy     (busy[1]),
        .quot     (qd_u),
        .rem      (rd_u)
    );

    tssg_div #(.X_WIDTH(XW)) u_div_lower (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.div_start),
        .dividend ((XW+1)'($signed(bx_reg)) - (XW+1)'($signed(mx_reg))),
        .divisor  (by_reg - my_reg),
        .busy     (busy[2]),
        .quot     (qd_w),
        .rem      (rd_w)
    );

    assign lower = (cur_row_reg >= my_reg);
    assign {step_ql, step_rl} = edge_step(ql_reg, rl_reg, qd_l, rd_l, by_reg - ty_reg);
    assign {step_qu, step_ru} = edge_step(qu_reg, ru_reg, qd_u, rd_u, my_reg - ty_reg);
    assign {step_qw, step_rw} = edge_step(qw_reg, rw_reg, qd_w, rd_w, by_reg - my_reg);

    always_ff @(posedge clk)
    begin
        if (cmd.init)
        begin
            ql_reg      <= tx_reg; rl_reg <= '0;
            qu_reg      <= tx_reg; ru_reg <= '0;
            qw_reg      <= mx_reg; rw_reg <= '0;
            cur_row_reg <= ty_reg;
        end
        else if (cmd.emit)
        begin
            ql_reg <= step_ql; rl_reg <= step_rl;
            // The upper edge only moves above the middle row, the lower edge from it on.
            if (lower)
            begin
                qw_reg <= step_qw; rw_reg <= step_rw;
            end
            else
            begin
                qu_reg <= step_qu; ru_reg <= step_ru;
            end
            cur_row_reg <= cur_row_reg + RW'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit)
        begin
            out_row_reg  <= cur_row_reg;
            out_xl_reg   <= trunc_x(ql_reg, rl_reg);
            out_xs_reg   <= lower ? trunc_x(qw_reg, rw_reg) : trunc_x(qu_reg, ru_reg);
            out_last_reg <= status.last_row;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.emit)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!span_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    assign status.flat     = (ty_reg == by_reg);
    assign status.div_busy = |busy;
    assign status.out_free = !out_valid_reg || !span_stall;
    assign status.last_row = (({1'b0, cur_row_reg} + (RW+1)'(1)) == {1'b0, by_reg});

    assign span_valid = out_valid_reg;
    assign row        = out_row_reg;
    assign x_long     = out_xl_reg;
    assign x_short    = out_xs_reg;
    assign last       = out_last_reg;

endmodule

/* src/tssg_ctrl.sv */
// Controller of the span generator: sequences load, divide, setup and span output.
// Uses the command and status structs of tssg_pkg.
module tssg_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              tri_valid,
    output logic              tri_stall,
    input  tssg_pkg::status_t status,
    output tssg_pkg::cmd_t    cmd
);

    typedef enum logic [1:0] {
        IDLE,
        SETUP,
        DIVIDE,
        SPAN
    } state_t;

    state_t state_reg, state_next;

    always_comb
    begin
        state_next    = state_reg;
        cmd           = '0;
        unique case (state_reg)
            IDLE:
            begin
                if (tri_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = SETUP;
                end
            end
            SETUP:
            begin
                if (status.flat)
                begin
                    state_next = IDLE;
                end
                else
                begin
                    cmd.div_start = 1'b1;
                    state_next    = DIVIDE;
                end
            end
            DIVIDE:
            begin
                if (!status.div_busy)
                begin
                    cmd.init   = 1'b1;
                    state_next = SPAN;
                end
            end
            SPAN:
            begin
                if (status.out_free)
                begin
                    cmd.emit = 1'b1;
                    if (status.last_row)
                    begin
                        state_next = IDLE;
                    end
                end
            end
            default:
            begin
                state_next = IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign tri_stall = (state_reg != IDLE);

endmodule

/* dv/triangle_scanline_span_generator_tb.sv */
`timescale 1ns / 1ps
// Self-checking testbench for triangle_scanline_span_generator.
// Depends on tssg_pkg and the RTL top; the scoreboard class predicts the spans of
// each accepted triangle and checks them in order against the span channel.
module triangle_scanline_span_generator_tb;

    localparam int XW = tssg_pkg::DEF_X_WIDTH;
    localparam int RW = tssg_pkg::ROW_W;
    localparam int ROWS = tssg_pkg::DEF_ROWS;
    localparam int IDLE_LIMIT = 4000;
    localparam int DRAIN_CYCLES = 4 * (XW + 4);
    localparam int PHASES = 5;
    localparam int ITEMS_PER_PHASE = 94;

    typedef struct {
        logic signed [XW-1:0] x;
        logic [RW-1:0]        y;
    } vertex_t;

    typedef struct {
        logic [RW-1:0]        row;
        logic signed [XW-1:0] x_long;
        logic signed [XW-1:0] x_short;
        logic                 last;
    } span_t;

    class span_scoreboard;
        span_t expected_spans[$];
        int    mismatches;

        // Exact x on the edge s -> e at t rows below s, truncated toward zero.
        function automatic logic signed [XW-1:0] edge_x_at(vertex_t s, vertex_t e, int t);
            longint dy;
            longint num;
            dy = longint'(e.y) - longint'(s.y);
            if (dy <= 0)
                return s.x;
            num = longint'(s.x) * dy + (longint'(e.x) - longint'(s.x)) * longint'(t);
            return XW'(num / dy);
        endfunction

        function void note_triangle(vertex_t a, vertex_t b, vertex_t c);
            vertex_t v[3];
            vertex_t tmp;
            span_t   s;
            int      m;
            bit      lower;
            v[0] = a;
            v[1] = b;
            v[2] = c;
            for (int i = 0; i < 3; i++)
            begin
                if (v[i].y > ROWS - 1)
                    v[i].y = RW'(ROWS - 1);
            end
            // Selection sort on y; an equal y at a later position takes the slot.
            for (int i = 0; i < 2; i++)
            begin
                m = i;
                for (int j = i; j < 3; j++)
                begin
                    if (v[j].y <= v[m].y)
                        m = j;
                end
                tmp = v[i];
                v[i] = v[m];
                v[m] = tmp;
            end
            for (int r = int'(v[0].y); r < int'(v[2].y); r++)
            begin
                lower = (r >= int'(v[1].y));
                s.row = RW'(r);
                s.x_long = edge_x_at(v[0], v[2], r - int'(v[0].y));
                s.x_short = lower ? edge_x_at(v[1], v[2], r - int'(v[1].y))
                                  : edge_x_at(v[0], v[1], r - int'(v[0].y));
                s.last = (r + 1 == int'(v[2].y));
                expected_spans.push_back(s);
            end
        endfunction

        function void check_span(span_t got);
            span_t want;
            if (expected_spans.size() == 0)
            begin
                $error("unexpected span: row %0d x_long %0d x_short %0d last %0b",
                       got.row, got.x_long, got.x_short, got.last);
                mismatches++;
                return;
            end
            want = expected_spans.pop_front();
            if (got.row !== want.row)
            begin
                $error("row: expected %0d, actual %0d", want.row, got.row);
                mismatches++;
            end
            if (got.x_long !== want.x_long)
            begin
                $error("x_long: expected %0d, actual %0d", want.x_long, got.x_long);
                mismatches++;
            end
            if (got.x_short !== want.x_short)
            begin
                $error("x_short: expected %0d, actual %0d", want.x_short, got.x_short);
                mismatches++;
            end
            if (got.last !== want.last)
            begin
                $error("last: expected %0b, actual %0b", want.last, got.last);
                mismatches++;
            end
        endfunction
    endclass

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 tri_valid = 1'b0;
    logic                 tri_stall;
    logic signed [XW-1:0] ax = '0;
    logic [RW-1:0]        ay = '0;
    logic signed [XW-1:0] bx = '0;
    logic [RW-1:0]        by = '0;
    logic signed [XW-1:0] cx = '0;
    logic [RW-1:0]        cy = '0;
    logic                 span_valid;
    logic                 span_stall = 1'b0;
    logic [RW-1:0]        row;
    logic signed [XW-1:0] x_long;
    logic signed [XW-1:0] x_short;
    logic                 last;

    span_scoreboard sb = new();
    int gap_pct = 0;
    int stall_pct = 0;
    int stall_left = 0;
    int idle_cycles = 0;
    int phase_gap[PHASES] = '{0, 20, 50, 10, 40};
    int phase_stall[PHASES] = '{0, 20, 10, 60, 40};

    triangle_scanline_span_generator DUT (
        .clk        (clk),
        .rst_n      (rst_n),
        .tri_valid  (tri_valid),
        .tri_stall  (tri_stall),
        .ax         (ax),
        .ay         (ay),
        .bx         (bx),
        .by         (by),
        .cx         (cx),
        .cy         (cy),
        .span_valid (span_valid),
        .span_stall (span_stall),
        .row        (row),
        .x_long     (x_long),
        .x_short    (x_short),
        .last       (last)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // Mostly short idle stretches, now and then a long one.
    function automatic int gap_len();
        if ($urandom_range(9) == 0)
            return $urandom_range(40, 12);
        return $urandom_range(3, 1);
    endfunction

    function automatic vertex_t mk(int x, int y);
        vertex_t v;
        v.x = XW'(x);
        v.y = RW'(y);
        return v;
    endfunction

    function automatic int rand_x();
        if ($urandom_range(7) == 0)
            return $urandom_range(1) ? -512 : 511;
        return int'($urandom_range(1023)) - 512;
    endfunction

    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (stall_left > 0)
            begin
                stall_left--;
                span_stall <= 1'b1;
            end
            else if (stall_pct != 0 && $urandom_range(99) < stall_pct)
            begin
                stall_left = gap_len() - 1;
                span_stall <= 1'b1;
            end
            else
                span_stall <= 1'b0;
        end
    end

    always @(posedge clk)
    begin
        span_t got;
        if (rst_n && span_valid && !span_stall)
        begin
            got.row = row;
            got.x_long = x_long;
            got.x_short = x_short;
            got.last = last;
            sb.check_span(got);
        end
        if ((tri_valid && !tri_stall) || (span_valid && !span_stall))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("tb: failure");
            $finish;
        end
    end

    task automatic send_tri(input vertex_t a, input vertex_t b, input vertex_t c);
        if (gap_pct != 0 && $urandom_range(99) < gap_pct)
        begin
            tri_valid <= 1'b0;
            repeat (gap_len()) @(negedge clk);
        end
        ax <= a.x;
        ay <= a.y;
        bx <= b.x;
        by <= b.y;
        cx <= c.x;
        cy <= c.y;
        tri_valid <= 1'b1;
        @(posedge clk);
        while (tri_stall)
            @(posedge clk);
        sb.note_triangle(a, b, c);
        @(negedge clk);
    endtask

    task automatic run_directed();
        // All rows equal: nothing comes out.
        send_tri(mk(0, 5), mk(10, 5), mk(-10, 5));
        // Flat top over the full height, x at both extremes.
        send_tri(mk(-512, 0), mk(511, 0), mk(0, 63));
        // Flat bottom over the full height.
        send_tri(mk(0, 0), mk(-512, 63), mk(511, 63));
        send_tri(mk(511, 63), mk(-512, 0), mk(100, 30));
        // Negative slopes, where truncation toward zero matters.
        send_tri(mk(-7, 10), mk(0, 13), mk(5, 11));
        send_tri(mk(3, 20), mk(3, 20), mk(3, 20));
        send_tri(mk(-1, 40), mk(1, 41), mk(0, 40));
        send_tri(mk(-512, 62), mk(511, 63), mk(-512, 63));
        send_tri(mk(341, 21), mk(-342, 42), mk(0, 0));
        send_tri(mk(-342, 42), mk(341, 21), mk(-1, 63));
        send_tri(mk(-1, 0), mk(0, 0), mk(-1, 63));
        send_tri(mk(100, 30), mk(-100, 30), mk(50, 30));
        send_tri(mk(0, 30), mk(0, 10), mk(0, 50));
        send_tri(mk(-512, 0), mk(-512, 63), mk(-512, 31));
        send_tri(mk(511, 63), mk(511, 0), mk(511, 32));
        // Ties on the top row and on the bottom row in different positions.
        send_tri(mk(200, 5), mk(-300, 5), mk(7, 9));
        send_tri(mk(7, 9), mk(200, 5), mk(-300, 9));
        send_tri(mk(-300, 9), mk(7, 5), mk(200, 9));
        send_tri(mk(-5, 1), mk(5, 2), mk(0, 3));
        send_tri(mk(511, 0), mk(-512, 1), mk(511, 2));
    endtask

    initial
    begin
        int ya;
        int yb;
        int yc;
        int base;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        gap_pct = 25;
        stall_pct = 25;
        run_directed();

        for (int p = 0; p < PHASES; p++)
        begin
            gap_pct = phase_gap[p];
            stall_pct = phase_stall[p];
            for (int k = 0; k < ITEMS_PER_PHASE; k++)
            begin
                base = $urandom_range(63);
                ya = $urandom_range(63);
                yb = $urandom_range(63);
                yc = $urandom_range(63);
                case ($urandom_range(9))
                    0:
                    begin
                        ya = base;
                        yb = base;
                        yc = base;
                    end
                    1:
                    begin
                        ya = base;
                        yc = $urandom_range(1) ? ya : yb;
                    end
                    2, 3, 4, 5:
                    begin
                        // Short triangles keep the run quick and hit many row offsets.
                        base = $urandom_range(55);
                        ya = base + $urandom_range(8);
                        yb = base + $urandom_range(8);
                        yc = base + $urandom_range(8);
                    end
                    default:
                    begin
                    end
                endcase
                send_tri(mk(rand_x(), ya), mk(rand_x(), yb), mk(rand_x(), yc));
            end
        end
        tri_valid <= 1'b0;

        while (sb.expected_spans.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (sb.mismatches == 0 && sb.expected_spans.size() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

/* files.f */
src/tssg_pkg.sv
src/tssg_div.sv
src/tssg_datapath.sv
src/tssg_ctrl.sv
src/triangle_scanline_span_generator.sv
dv/triangle_scanline_span_generator_tb.sv
